// ----- src/smb_pkg.sv -----
`default_nettype none

package smb_pkg;

    // build defaults
    localparam int NUM_ENTRIES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int ID_BITS_DEF     = 8;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // request function codes
    localparam logic [2:0] FUNC_CRT_BIN = 3'd0;
    localparam logic [2:0] FUNC_CRT_CNT = 3'd1;
    localparam logic [2:0] FUNC_CRT_MTX = 3'd2;
    localparam logic [2:0] FUNC_TAKE    = 3'd3;
    localparam logic [2:0] FUNC_GIVE    = 3'd4;
    localparam logic [2:0] FUNC_DELETE  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  handle;
        logic [7:0]  requester;
        logic [15:0] limit_in;
        logic [15:0] initial_in;
        logic        may_wait;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] handle_out;
        logic       wake;
    } t_rsp;

    // classified operation, rejected requests already folded into OP_FAIL
    typedef enum logic [2:0] {
        OP_CRT_BIN,
        OP_CRT_CNT,
        OP_CRT_MTX,
        OP_TAKE,
        OP_GIVE,
        OP_DELETE,
        OP_FAIL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  handle;
        logic [7:0]  requester;
        logic [15:0] limit_in;
        logic [15:0] initial_in;
        logic        may_wait;
    } t_cmd;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } t_bstate;

endpackage

`default_nettype wire

// ----- src/semaphore_mutex_bank_top.sv -----
// channel   | ports                  | handshake
// ----------+------------------------+-------------------------------------------
// request   | start, busy, i_req     | transaction when start high and busy low
// result    | o_valid, o_rsp         | one-cycle strobe, always taken
//
// each request is one read-modify-write of one entry: the back end pops a
// request and registers its entry record, then executes and writes back in
// its exec state, so it takes no new request until it is back in idle
// the result strobe and response are registered in the exec state, which
// follows the registering of the popped request and its entry record
// busy rises only when the two-entry command queue is full; results never stall
// synchronous active-low reset frees every entry; no clearing pass
`default_nettype none

module semaphore_mutex_bank_top
    import smb_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    // front to queue
    logic push;
    t_cmd push_cmd;
    // queue to back
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_cmd;

    // decode and range check, reject bad requests early
    smb_front #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_front (
        .i_start (start),
        .o_busy  (busy),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // short queue decoupling intake from execution
    smb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // entry storage, allocation and the read-modify-write engine
    smb_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_BITS  (COUNT_BITS),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ----- src/smb_front.sv -----
`default_nettype none

module smb_front
    import smb_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic i_start,
    output logic      o_busy,
    input  wire t_req i_req,
    input  wire logic i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic in_range;
    t_op  op;

    assign in_range = 32'(i_req.handle) < 32'(NUM_ENTRIES);

    always_comb begin
        case (i_req.func)
            FUNC_CRT_BIN: op = OP_CRT_BIN;
            FUNC_CRT_CNT: op = (i_req.limit_in == 16'd0) ? OP_FAIL : OP_CRT_CNT;
            FUNC_CRT_MTX: op = OP_CRT_MTX;
            FUNC_TAKE:    op = in_range ? OP_TAKE : OP_FAIL;
            FUNC_GIVE:    op = in_range ? OP_GIVE : OP_FAIL;
            FUNC_DELETE:  op = in_range ? OP_DELETE : OP_FAIL;
            default:      op = OP_FAIL;
        endcase
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_cmd.op         = op;
        o_cmd.handle     = i_req.handle;
        o_cmd.requester  = i_req.requester;
        o_cmd.limit_in   = i_req.limit_in;
        o_cmd.initial_in = i_req.initial_in;
        o_cmd.may_wait   = i_req.may_wait;
    end

endmodule

`default_nettype wire

// ----- src/smb_queue.sv -----
`default_nettype none

module smb_queue
    import smb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/smb_back.sv -----
`default_nettype none

module smb_back
    import smb_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                  is_mutex;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] limit;
        logic [ID_BITS-1:0]    owner;
    } t_entry;

    t_entry                 r_mem [NUM_ENTRIES];
    t_entry                 r_rd;
    logic [NUM_ENTRIES-1:0] r_used;
    logic [NUM_ENTRIES-1:0] n_used;
    t_bstate                r_state;
    t_bstate                n_state;
    t_cmd                   r_cmd;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_full;
    logic                   r_valid;
    logic                   n_valid;
    t_rsp                   r_rsp;
    t_rsp                   n_rsp;

    logic [IDX_W-1:0]       free_idx;
    logic                   any_free;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       cmd_idx;
    logic                   we;
    logic [IDX_W-1:0]       wr_idx;
    t_entry                 wr_rec;
    logic [ID_BITS-1:0]     req_id;
    logic                   sat;
    logic [COUNT_BITS-1:0]  lim_c;
    logic [COUNT_BITS-1:0]  ini_c;

    // lowest free entry, registered
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    assign rd_idx  = IDX_W'(i_cmd.handle);
    assign cmd_idx = IDX_W'(r_cmd.handle);
    assign req_id  = ID_BITS'(r_cmd.requester);

    // counting create: saturate limit to count width, clamp initial to limit
    assign sat   = r_cmd.limit_in > 16'(CNT_MAX);
    assign lim_c = sat ? CNT_MAX : COUNT_BITS'(r_cmd.limit_in);
    assign ini_c = (r_cmd.initial_in > lim_c) ? lim_c : COUNT_BITS'(r_cmd.initial_in);

    always_comb begin
        n_state           = r_state;
        o_pop             = 1'b0;
        n_valid           = 1'b0;
        n_rsp.status      = ST_FAIL;
        n_rsp.handle_out  = 4'd0;
        n_rsp.wake        = 1'b0;
        n_used            = r_used;
        we                = 1'b0;
        wr_idx            = cmd_idx;
        wr_rec            = r_rd;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                n_state = BS_IDLE;
                n_valid = 1'b1;
                case (r_cmd.op)
                    OP_CRT_BIN, OP_CRT_CNT, OP_CRT_MTX: begin
                        if (!r_full) begin
                            we              = 1'b1;
                            wr_idx          = r_free_idx;
                            wr_rec.is_mutex = (r_cmd.op == OP_CRT_MTX);
                            wr_rec.limit    = (r_cmd.op == OP_CRT_CNT) ? lim_c
                                                                       : COUNT_BITS'(1);
                            wr_rec.count    = (r_cmd.op == OP_CRT_CNT) ? ini_c : '0;
                            wr_rec.owner    = '0;
                            n_used[r_free_idx] = 1'b1;
                            n_rsp.status     = ST_OK;
                            n_rsp.handle_out = 4'(r_free_idx);
                        end
                    end
                    OP_TAKE: begin
                        if (r_used[cmd_idx]) begin
                            if (r_rd.is_mutex) begin
                                if (r_rd.count == '0) begin
                                    we           = 1'b1;
                                    wr_rec.count = COUNT_BITS'(1);
                                    wr_rec.owner = req_id;
                                    n_rsp.status = ST_OK;
                                end else if (r_rd.owner == req_id) begin
                                    n_rsp.status = ST_OK;
                                end else begin
                                    n_rsp.status = r_cmd.may_wait ? ST_WAIT : ST_FAIL;
                                end
                            end else if (r_rd.count != '0) begin
                                we           = 1'b1;
                                wr_rec.count = r_rd.count - 1'b1;
                                n_rsp.status = ST_OK;
                            end else begin
                                n_rsp.status = r_cmd.may_wait ? ST_WAIT : ST_FAIL;
                            end
                        end
                    end
                    OP_GIVE: begin
                        if (r_used[cmd_idx]) begin
                            if (r_rd.is_mutex) begin
                                if (r_rd.count != '0 && r_rd.owner == req_id) begin
                                    we           = 1'b1;
                                    wr_rec.count = '0;
                                    wr_rec.owner = '0;
                                    n_rsp.status = ST_OK;
                                    n_rsp.wake   = 1'b1;
                                end
                            end else if (r_rd.count < r_rd.limit) begin
                                we           = 1'b1;
                                wr_rec.count = r_rd.count + 1'b1;
                                n_rsp.status = ST_OK;
                                n_rsp.wake   = 1'b1;
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (r_used[cmd_idx]) begin
                            n_used[cmd_idx] = 1'b0;
                            n_rsp.status    = ST_OK;
                        end
                    end
                    default: begin
                        n_rsp.status = ST_FAIL;
                    end
                endcase
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_used     <= '0;
            r_valid    <= 1'b0;
            r_full     <= 1'b0;
            r_free_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_valid    <= n_valid;
            r_full     <= !any_free;
            r_free_idx <= free_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_rd  <= r_mem[rd_idx];
        end
        if (we) begin
            r_mem[wr_idx] <= wr_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ----- tb/semaphore_mutex_bank_top_tb.sv -----
`timescale 1ns / 100ps

module semaphore_mutex_bank_top_tb;
    import smb_pkg::*;

    localparam int          NUM_SLOTS      = 16;
    localparam int          WATCHDOG_LIMIT = 500;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          MAX_REPORTS    = 10;
    localparam int          PHASE_ITEMS    = 380;
    localparam int          SWING_ITEMS    = 50;
    // func codes the block does not define, both must fail
    localparam logic [2:0]  FUNC_RSVD6     = 3'd6;
    localparam logic [2:0]  FUNC_RSVD7     = 3'd7;
    localparam logic [15:0] COUNT_TOP      = 16'hFFFF;

    // shadow of the entry bank plus the transactions still owed a result
    class sem_bank_scoreboard;
        bit          used     [NUM_SLOTS];
        bit          is_mutex [NUM_SLOTS];
        logic [15:0] count    [NUM_SLOTS];
        logic [15:0] limit    [NUM_SLOTS];
        logic [7:0]  owner    [NUM_SLOTS];
        t_rsp        expected_rsp_q[$];
        int          n_errors;

        function new();
            n_errors = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function int first_free();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!used[i]) return i;
            end
            return -1;
        endfunction

        // apply one request to the shadow bank and return the response it earns
        function t_rsp predict_entry_op(t_req r);
            t_rsp o;
            int   e;
            int   h;
            o        = '0;
            o.status = ST_FAIL;
            h        = r.handle;
            case (r.func)
                FUNC_CRT_BIN, FUNC_CRT_CNT, FUNC_CRT_MTX: begin
                    e = first_free();
                    if (e >= 0 && !(r.func == FUNC_CRT_CNT && r.limit_in == '0)) begin
                        used[e]     = 1'b1;
                        is_mutex[e] = (r.func == FUNC_CRT_MTX);
                        limit[e]    = 16'd1;
                        count[e]    = '0;
                        owner[e]    = '0;
                        if (r.func == FUNC_CRT_CNT) begin
                            limit[e] = r.limit_in;
                            count[e] = (r.initial_in > r.limit_in) ? r.limit_in : r.initial_in;
                        end
                        o.status     = ST_OK;
                        o.handle_out = e[3:0];
                    end
                end
                FUNC_TAKE: if (used[h]) begin
                    if (is_mutex[h]) begin
                        if (count[h] == '0) begin
                            count[h] = 16'd1;
                            owner[h] = r.requester;
                            o.status = ST_OK;
                        end else if (owner[h] == r.requester) begin
                            o.status = ST_OK;
                        end else begin
                            o.status = r.may_wait ? ST_WAIT : ST_FAIL;
                        end
                    end else if (count[h] != '0) begin
                        count[h] = count[h] - 16'd1;
                        o.status = ST_OK;
                    end else begin
                        o.status = r.may_wait ? ST_WAIT : ST_FAIL;
                    end
                end
                FUNC_GIVE: if (used[h]) begin
                    if (is_mutex[h]) begin
                        if (count[h] != '0 && owner[h] == r.requester) begin
                            count[h] = '0;
                            owner[h] = '0;
                            o.status = ST_OK;
                            o.wake   = 1'b1;
                        end
                    end else if (count[h] < limit[h]) begin
                        count[h] = count[h] + 16'd1;
                        o.status = ST_OK;
                        o.wake   = 1'b1;
                    end
                end
                FUNC_DELETE: if (used[h]) begin
                    used[h]  = 1'b0;
                    o.status = ST_OK;
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_request(t_req r);
            expected_rsp_q.push_back(predict_entry_op(r));
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_rsp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result status %0d handle %0d wake %0d",
                             $time, got.status, got.handle_out, got.wake);
                return;
            end
            want = expected_rsp_q.pop_front();
            if (got.status !== want.status || got.handle_out !== want.handle_out ||
                got.wake !== want.wake) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: expected status %0d handle %0d wake %0d, got %0d %0d %0d",
                             $time, want.status, want.handle_out, want.wake,
                             got.status, got.handle_out, got.wake);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_rsp o_rsp;

    sem_bank_scoreboard sb;
    int                 n_accepted;
    int                 idle_cycles;
    int                 sender_idle_pct;

    semaphore_mutex_bank_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // sample both channels on the rising edge, before the block's own updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_request(i_req);
                n_accepted++;
            end
            if (o_valid) sb.check_result(o_rsp);
        end
    end

    // watchdog: too many cycles with no transaction on either side means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("semaphore_mutex_bank_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_req mk_req(logic [2:0] func, logic [3:0] handle, logic [7:0] requester,
                                    logic [15:0] lim, logic [15:0] ini, logic may_wait);
        t_req r;
        r.func       = func;
        r.handle     = handle;
        r.requester  = requester;
        r.limit_in   = lim;
        r.initial_in = ini;
        r.may_wait   = may_wait;
        return r;
    endfunction

    // random request; grow favors creates, otherwise deletes, so the bank
    // swings between empty and full
    function automatic t_req random_request(bit grow);
        t_req r;
        int   pick;
        int   create_pct;
        int   delete_pct;
        int   live[$];
        r          = '0;
        create_pct = grow ? 45 : 12;
        delete_pct = grow ? 5 : 30;
        pick       = $urandom_range(99);
        if (pick < 3) begin
            r.func = $urandom_range(1) ? FUNC_RSVD6 : FUNC_RSVD7;
        end else if (pick < 3 + create_pct) begin
            case ($urandom_range(2))
                0:       r.func = FUNC_CRT_BIN;
                1:       r.func = FUNC_CRT_CNT;
                default: r.func = FUNC_CRT_MTX;
            endcase
        end else if (pick < 3 + create_pct + delete_pct) begin
            r.func = FUNC_DELETE;
        end else begin
            r.func = $urandom_range(1) ? FUNC_TAKE : FUNC_GIVE;
        end
        // mostly address live entries so take and give get past the free check
        for (int i = 0; i < NUM_SLOTS; i++) if (sb.used[i]) live.push_back(i);
        if (live.size() > 0 && $urandom_range(9) != 0)
            r.handle = 4'(live[$urandom_range(live.size() - 1)]);
        else
            r.handle = 4'($urandom_range(15));
        // small pool of thread ids so mutex ownership collides often
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
                0:       r.requester = 8'h00;
                1:       r.requester = 8'hFF;
                2:       r.requester = 8'h5A;
                default: r.requester = 8'hA5;
            endcase
        end else begin
            r.requester = 8'($urandom_range(255));
        end
        case ($urandom_range(7))
            0:       r.limit_in = '0;
            1:       r.limit_in = COUNT_TOP;
            2:       r.limit_in = 16'($urandom_range(65535));
            default: r.limit_in = 16'($urandom_range(1, 4));
        endcase
        case ($urandom_range(3))
            0:       r.initial_in = '0;
            1:       r.initial_in = COUNT_TOP;
            2:       r.initial_in = 16'($urandom_range(65535));
            default: r.initial_in = 16'($urandom_range(4));
        endcase
        r.may_wait = 1'($urandom_range(1));
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(t_req r);
        int target;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        target = n_accepted + 1;
        start  = 1'b1;
        i_req  = r;
        do @(negedge i_clk); while (n_accepted < target);
    endtask

    task automatic wait_drain();
        start = 1'b0;
        while (sb.expected_rsp_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb              = new();
        n_accepted      = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        start           = 1'b0;
        i_req           = '0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // operations on a bank that holds nothing yet, and the unused func codes
        send(mk_req(FUNC_TAKE,   4'd0,  8'h00, '0, '0, 1'b1));
        send(mk_req(FUNC_GIVE,   4'd15, 8'hFF, '0, '0, 1'b0));
        send(mk_req(FUNC_DELETE, 4'd7,  8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_RSVD6,  4'd0,  8'h00, COUNT_TOP, COUNT_TOP, 1'b1));
        send(mk_req(FUNC_RSVD7,  4'd15, 8'hFF, COUNT_TOP, COUNT_TOP, 1'b1));
        // counting create with a zero limit takes no entry
        send(mk_req(FUNC_CRT_CNT, 4'd0, 8'h00, '0, 16'd5, 1'b0));
        // binary semaphore: empty take fails or waits, give wakes, second give at limit
        send(mk_req(FUNC_CRT_BIN, 4'd0, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd0, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd0, 8'h00, '0, '0, 1'b1));
        send(mk_req(FUNC_GIVE,    4'd0, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_GIVE,    4'd0, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd0, 8'h00, '0, '0, 1'b0));
        // counting semaphore created full at the widest limit
        send(mk_req(FUNC_CRT_CNT, 4'd0, 8'h00, COUNT_TOP, COUNT_TOP, 1'b0));
        send(mk_req(FUNC_GIVE,    4'd1, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd1, 8'h00, '0, '0, 1'b0));
        // initial count above the limit gets clamped
        send(mk_req(FUNC_CRT_CNT, 4'd0, 8'h00, 16'd3, COUNT_TOP, 1'b0));
        // mutex: owner re-take, foreign take and give, owner give, give when free
        send(mk_req(FUNC_CRT_MTX, 4'd0, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd3, 8'hFF, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd3, 8'hFF, '0, '0, 1'b0));
        send(mk_req(FUNC_TAKE,    4'd3, 8'h00, '0, '0, 1'b1));
        send(mk_req(FUNC_TAKE,    4'd3, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_GIVE,    4'd3, 8'h00, '0, '0, 1'b0));
        send(mk_req(FUNC_GIVE,    4'd3, 8'hFF, '0, '0, 1'b0));
        send(mk_req(FUNC_GIVE,    4'd3, 8'hFF, '0, '0, 1'b0));
        send(mk_req(FUNC_DELETE,  4'd2, 8'h00, '0, '0, 1'b0));

        // random phases: back to back, mostly idle sender, lightly idle sender, back to back again
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       sender_idle_pct = 73;
                2:       sender_idle_pct = 15;
                default: sender_idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send(random_request(((n / SWING_ITEMS) % 2) == 0));
            // after the first phase, hold off until the block has answered everything outstanding
            if (phase == 0) wait_drain();
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.expected_rsp_q.size() != 0) sb.n_errors++;
        if (sb.n_errors == 0) begin
            $display("semaphore_mutex_bank_top test passed");
        end else begin
            $display("semaphore_mutex_bank_top test failed");
        end
        $finish;
    end

endmodule

// ----- semaphore_mutex_bank_top.f -----
src/smb_pkg.sv
src/smb_front.sv
src/smb_queue.sv
src/smb_back.sv
src/semaphore_mutex_bank_top.sv
tb/semaphore_mutex_bank_top_tb.sv
